// ===== rtl/core/gtlo_pkg.sv =====
// Package for the geodetic to local offset unit: formats, constants, CORDIC table.
// Used by every module in rtl/core; depends on nothing.
package gtlo_pkg;

    localparam int unsigned CordicStepsDef = 24;
    localparam int unsigned MaxSteps      = 32;
    localparam int unsigned AngW          = 34;   // signed half units of 1e-7 degree
    localparam int unsigned QW            = 36;   // CORDIC datapath width, Q2.30 + guard

    localparam logic [33:0] HalfUnits90  = 34'd1800000000;
    localparam logic [33:0] HalfUnits360 = 34'd7200000000;
    localparam logic [31:0] PiQ30        = 32'd3373259426;
    localparam logic [31:0] GainQ30      = 32'd652032874;
    localparam logic [33:0] TwoRmm       = 34'd12742000000;
    localparam logic signed [36:0] XyLimit = 37'sd14000000000;
    localparam logic signed [36:0] ZLimit  = 37'sd5300000000;

    // half units of 90 degrees to Q2.30 radians: divisor, rounding term, reciprocal
    localparam logic [31:0] ZDiv     = 32'd3600000000;
    localparam logic [31:0] ZRound   = 32'd1800000000;
    localparam logic [31:0] RecipQ32 = 32'(({32'd0, PiQ30} << 32) / {32'd0, ZDiv});

    // register indexes
    localparam logic [2:0] RegOriginLat = 3'd0;
    localparam logic [2:0] RegOriginLon = 3'd1;
    localparam logic [2:0] RegOriginAlt = 3'd2;
    localparam logic [2:0] RegOffsetX   = 3'd3;
    localparam logic [2:0] RegOffsetY   = 3'd4;
    localparam logic [2:0] RegOffsetZ   = 3'd5;

    typedef logic signed [QW-1:0] t_q;

    // one angle in flight through the cell row
    typedef struct packed {
        t_q         x;
        t_q         y;
        t_q         z;
        logic [1:0] quad;
    } t_rot;

    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] t;
        unique case (i)
            5'd0:  t = 32'h3243F6A8; 5'd1:  t = 32'h1DAC6705;
            5'd2:  t = 32'h0FADBAFC; 5'd3:  t = 32'h07F56EA6;
            5'd4:  t = 32'h03FEAB76; 5'd5:  t = 32'h01FFD55B;
            5'd6:  t = 32'h00FFFAAA; 5'd7:  t = 32'h007FFF55;
            5'd8:  t = 32'h003FFFEA; 5'd9:  t = 32'h001FFFFD;
            5'd10: t = 32'h000FFFFF; 5'd11: t = 32'h0007FFFF;
            5'd12: t = 32'h0003FFFF; 5'd13: t = 32'h0001FFFF;
            5'd14: t = 32'h0000FFFF; 5'd15: t = 32'h00007FFF;
            5'd16: t = 32'h00003FFF; 5'd17: t = 32'h00001FFF;
            5'd18: t = 32'h00000FFF; 5'd19: t = 32'h000007FF;
            5'd20: t = 32'h000003FF; 5'd21: t = 32'h000001FF;
            5'd22: t = 32'h000000FF; 5'd23: t = 32'h0000007F;
            5'd24: t = 32'h0000003F; 5'd25: t = 32'h0000001F;
            5'd26: t = 32'h0000000F; 5'd27: t = 32'h00000008;
            5'd28: t = 32'h00000004; 5'd29: t = 32'h00000002;
            5'd30: t = 32'h00000001; default: t = 32'h00000000;
        endcase
        return t;
    endfunction

endpackage

// ===== rtl/core/geodetic_to_local_offset_unit.sv =====
// Top level of the geodetic to local offset unit.
// Depends on gtlo_pkg and gtlo_sincos.

// Converts one GNSS fix per word into east/north/up millimetres from the
// configured origin. The datapath is a fully pipelined row of CORDIC cells
// (three rows, one per angle) stalled as a whole: a word is accepted every
// cycle while the output word is not held, through three angle stages, one cell
// per CORDIC step, three multiply/scale/offset stages, one clamp output register.
// The whole pipeline freezes while the output word is held. No clearing pass.
module geodetic_to_local_offset_unit import gtlo_pkg::*; #(
    parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // fix_lat[30:0], fix_lon[62:31], fix_alt[94:63], zero pad
    input  logic [95:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // east_mm[34:0], north_mm[69:35], up_mm[103:70], zero pad
    output logic [103:0] m_axis_tdata
);
    localparam int unsigned N   = (CORDIC_STEPS > MaxSteps) ? MaxSteps : CORDIC_STEPS;
    localparam int unsigned Lat = N + 6;   // stages ahead of output register

    logic signed [30:0] r_olat, r_ox, r_oy, r_oz;
    logic signed [31:0] r_olon, r_oalt;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_olat <= '0; r_olon <= '0; r_oalt <= '0;
            r_ox <= '0; r_oy <= '0; r_oz <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                RegOriginLat: r_olat <= i_cfg_data[30:0];
                RegOriginLon: r_olon <= i_cfg_data;
                RegOriginAlt: r_oalt <= i_cfg_data;
                RegOffsetX:   r_ox   <= i_cfg_data[30:0];
                RegOffsetY:   r_oy   <= i_cfg_data[30:0];
                RegOffsetZ:   r_oz   <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    logic w_en;
    logic [Lat-1:0] r_vld;
    assign w_en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    logic signed [30:0] w_lat;
    logic signed [31:0] w_lon, w_alt;
    assign w_lat = s_axis_tdata[30:0];
    assign w_lon = s_axis_tdata[62:31];
    assign w_alt = s_axis_tdata[94:63];

    logic signed [AngW-1:0] w_amean, w_alon, w_alat;
    assign w_amean = AngW'(w_lat) + AngW'(r_olat);
    assign w_alon  = AngW'(w_lon) - AngW'(r_olon);
    assign w_alat  = AngW'(w_lat) - AngW'(r_olat);

    t_q w_sm, w_cm, w_sh, w_ch, w_sl, w_cl;
    gtlo_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_mean (
        .i_clk(i_clk), .i_en(w_en), .i_ang(w_amean), .o_sin(w_sm), .o_cos(w_cm));
    gtlo_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_lon (
        .i_clk(i_clk), .i_en(w_en), .i_ang(w_alon), .o_sin(w_sh), .o_cos(w_ch));
    gtlo_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_lat (
        .i_clk(i_clk), .i_en(w_en), .i_ang(w_alat), .o_sin(w_sl), .o_cos(w_cl));

    // altitude delay line alongside the cell rows
    logic signed [33:0] r_up [N+6];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_up[0] <= 34'(w_alt) - 34'(r_oalt) + 34'(r_oz);
            for (int k = 1; k < N + 6; k++) r_up[k] <= r_up[k-1];
        end
    end

    // magnitude of a signed value
    function automatic logic [QW-1:0] f_mag(input t_q v);
        return v[QW-1] ? QW'(-v) : QW'(v);
    endfunction

    // magnitudes stay below 2^31 in Q2.30
    logic [QW-1:0] w_cmm, w_shm, w_slm;
    assign w_cmm = f_mag(w_cm);
    assign w_shm = f_mag(w_sh);

    // stage A: cos(mean)*sin(half lon), rounded half away from zero
    logic [2*QW-1:0] w_pa;
    logic [QW-1:0]   r_pa;   // magnitude Q2.30
    logic            r_na;
    logic signed [QW-1:0] r_sl;
    assign w_pa = (72'(w_cmm[30:0]) * 72'(w_shm[30:0]) + (72'd1 << 29)) >> 30;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pa <= w_pa[QW-1:0];
            r_na <= w_cm[QW-1] ^ w_sh[QW-1];
            r_sl <= w_sl;
        end
    end

    // stage B: scale by 2R (magnitudes < 2^31 * 2^34 fit in 66 bits)
    logic [65:0] w_eb, w_nb;
    logic [35:0] r_em, r_nm;
    logic        r_ne, r_nn;
    assign w_slm = f_mag(r_sl);
    assign w_eb = (66'(r_pa[30:0]) * 66'(TwoRmm) + (66'd1 << 29)) >> 30;
    assign w_nb = (66'(w_slm[30:0]) * 66'(TwoRmm) + (66'd1 << 29)) >> 30;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_em <= w_eb[35:0]; r_ne <= r_na;
            r_nm <= w_nb[35:0]; r_nn <= r_sl[QW-1];
        end
    end

    // stage C: apply sign and offsets
    logic signed [36:0] r_e, r_n;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e <= (r_ne ? -$signed({1'b0, r_em}) : $signed({1'b0, r_em})) + 37'(r_ox);
            r_n <= (r_nn ? -$signed({1'b0, r_nm}) : $signed({1'b0, r_nm})) + 37'(r_oy);
        end
    end

    function automatic logic signed [36:0] f_clamp(input logic signed [36:0] v,
                                                   input logic signed [36:0] lim);
        return (v > lim) ? lim : ((v < -lim) ? -lim : v);
    endfunction

    logic signed [36:0] w_ec, w_nc, w_uc;
    assign w_ec = f_clamp(r_e, XyLimit);
    assign w_nc = f_clamp(r_n, XyLimit);
    assign w_uc = f_clamp(37'(r_up[N+5]), ZLimit);

    // valid tracking and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            m_axis_tvalid <= 1'b0;
        end else if (w_en) begin
            r_vld <= {r_vld[Lat-2:0], s_axis_tvalid};
            m_axis_tvalid <= r_vld[Lat-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            m_axis_tdata <= {w_uc[33:0], w_nc[34:0], w_ec[34:0]};
        end
    end

    logic w_unused;
    assign w_unused = ^{w_ch, w_cl, w_sm};
endmodule

// ===== rtl/core/gtlo_cell.sv =====
// One CORDIC rotation cell: a fixed micro-rotation on the word in flight.
// Depends on gtlo_pkg.
module gtlo_cell import gtlo_pkg::*; #(
    parameter int unsigned STEP = 0
) (
    input  logic i_clk,
    input  logic i_en,
    input  t_rot i_rot,
    output t_rot o_rot
);
    localparam logic [4:0] StepIdx = STEP[4:0];
    t_q   w_atan;
    t_rot n_rot;
    t_rot r_rot;

    assign w_atan = t_q'({4'd0, atan_q30(StepIdx)});

    // rotate toward z = 0, shifts are arithmetic
    always_comb begin
        n_rot = i_rot;
        if (!i_rot.z[QW-1]) begin
            n_rot.x = i_rot.x - (i_rot.y >>> STEP);
            n_rot.y = i_rot.y + (i_rot.x >>> STEP);
            n_rot.z = i_rot.z - w_atan;
        end else begin
            n_rot.x = i_rot.x + (i_rot.y >>> STEP);
            n_rot.y = i_rot.y - (i_rot.x >>> STEP);
            n_rot.z = i_rot.z + w_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot <= n_rot;
        end
    end

    assign o_rot = r_rot;
endmodule

// ===== rtl/core/gtlo_angle.sv =====
// Angle front end: reduces a half-unit angle mod 360 degrees and scales to Q2.30.
// Three register stages; depends on gtlo_pkg.
module gtlo_angle import gtlo_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [AngW-1:0] i_ang,
    output t_rot                   o_rot
);
    logic [33:0] w_r;
    logic [1:0]  w_q;
    logic [33:0] w_f;
    logic [30:0] r_f;
    logic [1:0]  r_q1;
    logic [63:0] w_pe;
    logic [63:0] w_pn;
    logic [30:0] r_est;
    logic [34:0] r_nlo;
    logic [1:0]  r_q2;
    logic [63:0] w_pd;
    logic [34:0] w_rem;
    logic [31:0] w_z;

    // |angle| < 2*360 deg, so at most two full-turn corrections bring it into range
    always_comb begin
        logic signed [AngW:0] a;
        a = {i_ang[AngW-1], i_ang};
        if (a < 0)
            a = a + $signed({1'b0, HalfUnits360});
        if (a >= $signed({1'b0, HalfUnits360}))
            a = a - $signed({1'b0, HalfUnits360});
        if (a < 0)
            a = a + $signed({1'b0, HalfUnits360});
        w_r = a[33:0];
        if (w_r >= 3 * HalfUnits90) begin
            w_q = 2'd3; w_f = w_r - 3 * HalfUnits90;
        end else if (w_r >= 2 * HalfUnits90) begin
            w_q = 2'd2; w_f = w_r - 2 * HalfUnits90;
        end else if (w_r >= HalfUnits90) begin
            w_q = 2'd1; w_f = w_r - HalfUnits90;
        end else begin
            w_q = 2'd0; w_f = w_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f  <= w_f[30:0];
            r_q1 <= w_q;
        end
    end

    // z = floor((f*pi + 1.8e9) / 3.6e9): reciprocal estimate is exact or one low,
    // low bits of the numerator kept for the remainder check
    assign w_pe = 64'(r_f) * 64'(RecipQ32);
    assign w_pn = 64'(r_f) * 64'(PiQ30) + 64'(ZRound);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_est <= w_pe[62:32];
            r_nlo <= w_pn[34:0];
            r_q2  <= r_q1;
        end
    end

    // remainder below 2*3.6e9, so one compare fixes the estimate
    assign w_pd  = 64'(r_est) * 64'(ZDiv);
    assign w_rem = r_nlo - w_pd[34:0];
    assign w_z   = {1'b0, r_est} + ((w_rem >= 35'(ZDiv)) ? 32'd1 : 32'd0);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rot.x    <= t_q'({4'd0, GainQ30});
            o_rot.y    <= '0;
            o_rot.z    <= t_q'({4'd0, w_z});
            o_rot.quad <= r_q2;
        end
    end
endmodule

// ===== rtl/core/gtlo_sincos.sv =====
// Sine/cosine unit: angle front end followed by a row of CORDIC cells.
// Depends on gtlo_pkg, gtlo_angle, gtlo_cell.
module gtlo_sincos import gtlo_pkg::*; #(
    parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [AngW-1:0] i_ang,
    output t_q                     o_sin,
    output t_q                     o_cos
);
    localparam int unsigned N = (CORDIC_STEPS > MaxSteps) ? MaxSteps : CORDIC_STEPS;
    t_rot w_chain [N+1];

    gtlo_angle u_angle (
        .i_clk (i_clk), .i_en (i_en), .i_ang (i_ang), .o_rot (w_chain[0])
    );

    for (genvar g = 0; g < N; g++) begin : g_cell
        gtlo_cell #(.STEP(g)) u_cell (
            .i_clk (i_clk), .i_en (i_en), .i_rot (w_chain[g]), .o_rot (w_chain[g+1])
        );
    end

    // quadrant fold
    always_comb begin
        unique case (w_chain[N].quad)
            2'd0: begin o_sin = w_chain[N].y;  o_cos = w_chain[N].x;  end
            2'd1: begin o_sin = w_chain[N].x;  o_cos = -w_chain[N].y; end
            2'd2: begin o_sin = -w_chain[N].y; o_cos = -w_chain[N].x; end
            default: begin o_sin = -w_chain[N].x; o_cos = w_chain[N].y; end
        endcase
    end
endmodule

// ===== test/tb.sv =====
// Testbench for geodetic_to_local_offset_unit: fixes in, east/north/up words out.
// Depends on gtlo_pkg and the unit; predicts each word with its own CORDIC model.
`timescale 1ns / 100ps

class fix_scoreboard;
    logic [103:0] pending[$];
    int           fails;

    function void note_fix(logic [103:0] expected);
        pending.push_back(expected);
    endfunction

    // returns 0 on a mismatch or when no word is pending, so the caller can report it
    function bit check_word(logic [103:0] got, output logic [103:0] want, output bit orphan);
        orphan = 0;
        want   = '0;
        if (pending.size() == 0) begin
            orphan = 1;
            return 0;
        end
        want = pending.pop_front();
        return (got == want);
    endfunction
endclass

module tb;
    import gtlo_pkg::*;

    localparam int Steps   = CordicStepsDef;
    localparam int Latency = Steps + 7;
    localparam int Limit   = 20000;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_cfg_we = 0;
    logic [2:0]   i_cfg_idx = '0;
    logic [31:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [103:0] m_axis_tdata;

    geodetic_to_local_offset_unit #(.CORDIC_STEPS(Steps)) dut (.*);

    always #1 i_clk = ~i_clk;

    fix_scoreboard sb = new();
    int  errors;
    int  idle_cycles;
    bit  stall_mode;

    // current origin and offsets
    longint org_lat, org_lon, org_alt, off_x, off_y, off_z;

    function automatic longint sx(longint v, int w);
        longint m = (64'sd1 <<< w) - 1;
        v = v & m;
        if (v[w-1]) v = v - (64'sd1 <<< w);
        return v;
    endfunction

    function automatic longint asr64(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint q30_mul(longint a, longint b);
        logic [63:0] ma, mb, p;
        bit neg;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? -a : a;
        mb  = (b < 0) ? -b : b;
        p   = (ma * mb + 64'd536870912) >> 30;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    // sine and cosine of an angle in half units of 1e-7 degree, Q2.30
    function automatic void sin_cos(input longint a2, output longint s, output longint c);
        longint r, q, f, x, y, z, nx;
        logic [63:0] num;
        r = a2 % 64'sd7200000000;
        if (r < 0) r += 64'sd7200000000;
        q = r / 64'sd1800000000;
        f = r - q * 64'sd1800000000;
        num = 64'(f) * 64'd3373259426 + 64'd1800000000;
        z = longint'(num / 64'd3600000000);
        x = GainQ30;
        y = 0;
        for (int i = 0; i < (Steps > 32 ? 32 : Steps); i++) begin
            if (z >= 0) begin
                nx = x - asr64(y, i);
                y  = y + asr64(x, i);
                z  = z - longint'(atan_q30(i[4:0]));
            end else begin
                nx = x + asr64(y, i);
                y  = y - asr64(x, i);
                z  = z + longint'(atan_q30(i[4:0]));
            end
            x = nx;
        end
        case (q)
            0: begin s = y;  c = x;  end
            1: begin s = x;  c = -y; end
            2: begin s = -y; c = -x; end
            default: begin s = -x; c = y; end
        endcase
    endfunction

    function automatic longint clip(longint v, longint lim);
        return v > lim ? lim : (v < -lim ? -lim : v);
    endfunction

    function automatic logic [103:0] predict_local(logic [95:0] d);
        longint lat, lon, alt, sm, cm, sh, ch, sl, cl, e, n, u;
        logic [103:0] w;
        lat = sx(longint'(d[30:0]), 31);
        lon = sx(longint'(d[62:31]), 32);
        alt = sx(longint'(d[94:63]), 32);
        sin_cos(org_lat + lat, sm, cm);
        sin_cos(lon - org_lon, sh, ch);
        sin_cos(lat - org_lat, sl, cl);
        e = q30_mul(q30_mul(cm, sh), 64'sd12742000000) + off_x;
        n = q30_mul(sl, 64'sd12742000000) + off_y;
        u = alt - org_alt + off_z;
        w = '0;
        w[34:0]   = 35'(clip(e, 64'sd14000000000));
        w[69:35]  = 35'(clip(n, 64'sd14000000000));
        w[103:70] = 34'(clip(u, 64'sd5300000000));
        return w;
    endfunction

    task automatic report_mismatch(string what, logic [103:0] got, logic [103:0] want);
        $display("tb: mismatch %s got %h want %h", what, got, want);
        errors++;
    endtask

    // write enable stays high for back-to-back writes; the caller drops it
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_we   <= 1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            RegOriginLat: org_lat = sx(longint'(val), 31);
            RegOriginLon: org_lon = sx(longint'(val), 32);
            RegOriginAlt: org_alt = sx(longint'(val), 32);
            RegOffsetX:   off_x   = sx(longint'(val), 31);
            RegOffsetY:   off_y   = sx(longint'(val), 31);
            RegOffsetZ:   off_z   = sx(longint'(val), 31);
            default: ;
        endcase
    endtask

    task automatic send_fix(logic [30:0] lat, logic [31:0] lon, logic [31:0] alt);
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {1'b0, alt, lon, lat};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_fix(predict_local({1'b0, alt, lon, lat}));
    endtask

    task automatic drain;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (Latency + 4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd_in(longint lo, longint hi);
        case ($urandom_range(0, 5))
            0: return 32'(lo);
            1: return 32'(hi);
            2: return $urandom();
            default: return 32'(lo + longint'($urandom_range(0, 32'hFFFFFFFF))
                                % (hi - lo + 1));
        endcase
    endfunction

    // random burst/gap sender: tvalid drops for each non-zero gap and at the end
    task automatic random_fixes(int count);
        int burst;
        int gap;
        while (count > 0) begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && count > 0) begin
                send_fix(31'(rnd_in(-900000000, 900000000)),
                         rnd_in(-1800000000, 1800000000), $urandom());
                burst--;
                count--;
            end
            gap = $urandom_range(0, 6);
            if (gap > 0 || count == 0) begin
                s_axis_tvalid <= 0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // receiver stall pattern and checker
    always @(posedge i_clk) begin
        logic [103:0] want;
        bit orphan;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (!sb.check_word(m_axis_tdata, want, orphan)) begin
                if (orphan) report_mismatch("unexpected word", m_axis_tdata, want);
                else report_mismatch("result", m_axis_tdata, want);
            end
        end
        if ($urandom_range(0, 199) == 0) stall_mode <= !stall_mode;
        m_axis_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end

    // watchdog on cycles without any accepted word
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || !i_rst_n)
            idle_cycles <= 0;
        else if (++idle_cycles >= Limit) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        org_lat = 0; org_lon = 0; org_alt = 0; off_x = 0; off_y = 0; off_z = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes with default origin
        send_fix(31'(-900000000), -1800000000, 32'h80000000);
        send_fix(31'(900000000), 1800000000, 32'h7FFFFFFF);
        send_fix('0, '0, '0);
        send_fix(31'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_fix(31'h40000000, 32'h80000000, 32'h00000000);
        send_fix(31'd450000000, 32'd900000000, 32'd1000);
        s_axis_tvalid <= 0;
        drain();

        // extreme origin and offsets: saturation and unwrapped longitude
        write_reg(RegOriginLat, 32'(-900000000));
        write_reg(RegOriginLon, 32'(-1800000000));
        write_reg(RegOriginAlt, 32'h7FFFFFFF);
        write_reg(RegOffsetX, 32'(1000000000));
        write_reg(RegOffsetY, 32'(-1000000000));
        write_reg(RegOffsetZ, 32'(-1000000000));
        write_reg(3'd7, 32'hFFFFFFFF);
        i_cfg_we <= 0;
        send_fix(31'(900000000), 1800000000, 32'h80000000);
        send_fix(31'(-900000000), -1800000000, 32'h7FFFFFFF);
        send_fix(31'h3FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
        send_fix('0, 32'd1800000000, '0);
        s_axis_tvalid <= 0;
        drain();

        // random phases, each with fresh settings
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(RegOriginLat, ph == 3 ? 32'd900000000 : rnd_in(-900000000, 900000000));
            write_reg(RegOriginLon, ph == 3 ? 32'd1800000000 : rnd_in(-1800000000, 1800000000));
            write_reg(RegOriginAlt, ph == 3 ? 32'h80000000 : $urandom());
            write_reg(RegOffsetX, ph == 0 ? 32'd0 : rnd_in(-1000000000, 1000000000));
            write_reg(RegOffsetY, ph == 0 ? 32'd0 : rnd_in(-1000000000, 1000000000));
            write_reg(RegOffsetZ, ph == 3 ? 32'd1000000000 : rnd_in(-1000000000, 1000000000));
            i_cfg_we <= 0;
            random_fixes(350);
            drain();
        end

        if (errors == 0) $display("tb: PASS");
        else $display("tb: FAIL");
        $finish;
    end
endmodule
